>>> rtl/bpg_pkg.sv
`default_nettype none

package bpg_pkg;

    // Item kinds carried in the slave-side tuser
    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_SINGLE = 2'd1;
    localparam logic [1:0] CMD_REPEAT = 2'd2;
    localparam logic [1:0] CMD_TONE   = 2'd3;

    // Input field widths as they sit on the bus
    localparam int BEEP_W   = 16;
    localparam int SILENT_W = 16;
    localparam int COUNT_W  = 8;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 8;

    // Pattern run mode
    typedef enum logic [2:0] {
        MODE_IDLE   = 3'b001,
        MODE_SINGLE = 3'b010,
        MODE_REPEAT = 3'b100
    } t_mode;

    // One result item
    typedef struct packed {
        logic pin_level;
        logic busy_res;
        logic sounding;
        logic finished;
    } t_result;

endpackage

`default_nettype wire

>>> rtl/bpg_core.sv
`default_nettype none

module bpg_core
    import bpg_pkg::*;
#(
    parameter int TICK_WIDTH  = 16,
    parameter int COUNT_WIDTH = 8
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_accept,
    input  wire logic [1:0]          i_cmd,
    input  wire logic [BEEP_W-1:0]   i_beep_ticks,
    input  wire logic [SILENT_W-1:0] i_silent_ticks,
    input  wire logic [COUNT_W-1:0]  i_repeat_count,
    output t_result                  o_result
);

    t_mode                  r_mode,   n_mode;
    logic                   r_beep,   n_beep;
    logic [TICK_WIDTH-1:0]  r_phase,  n_phase;
    logic [COUNT_WIDTH-1:0] r_cycles, n_cycles;
    logic [TICK_WIDTH-1:0]  r_sound,  n_sound;
    logic [TICK_WIDTH-1:0]  r_quiet,  n_quiet;
    logic [COUNT_WIDTH-1:0] r_target, n_target;
    logic                   r_drive,  n_drive;
    logic                   w_done;

    logic [31:0]            w_beep_ext;
    logic [31:0]            w_silent_ext;
    logic [31:0]            w_count_ext;
    logic [TICK_WIDTH-1:0]  w_phase_inc;
    logic [COUNT_WIDTH-1:0] w_cycles_inc;

    // Fit the bus fields to the configured counter widths
    assign w_beep_ext   = {{(32-BEEP_W){1'b0}}, i_beep_ticks};
    assign w_silent_ext = {{(32-SILENT_W){1'b0}}, i_silent_ticks};
    assign w_count_ext  = {{(32-COUNT_W){1'b0}}, i_repeat_count};
    assign w_phase_inc  = r_phase + {{(TICK_WIDTH-1){1'b0}}, 1'b1};
    assign w_cycles_inc = r_cycles + {{(COUNT_WIDTH-1){1'b0}}, 1'b1};

    // Next pattern state for the current item
    always_comb begin
        n_mode   = r_mode;
        n_beep   = r_beep;
        n_phase  = r_phase;
        n_cycles = r_cycles;
        n_sound  = r_sound;
        n_quiet  = r_quiet;
        n_target = r_target;
        n_drive  = r_drive;
        w_done   = 1'b0;
        unique case (i_cmd)
            CMD_TICK: begin
                priority if (r_mode == MODE_SINGLE) begin
                    if (w_phase_inc >= r_sound) begin
                        n_mode  = MODE_IDLE;
                        n_beep  = 1'b0;
                        n_phase = '0;
                        w_done  = 1'b1;
                    end else begin
                        n_phase = w_phase_inc;
                    end
                end else if (r_mode == MODE_REPEAT && r_beep) begin
                    if (w_phase_inc >= r_sound) begin
                        n_beep  = 1'b0;
                        n_phase = '0;
                    end else begin
                        n_phase = w_phase_inc;
                    end
                end else if (r_mode == MODE_REPEAT) begin
                    if (w_phase_inc >= r_quiet) begin
                        n_cycles = w_cycles_inc;
                        n_phase  = '0;
                        if (w_cycles_inc >= r_target) begin
                            n_mode = MODE_IDLE;
                            n_beep = 1'b0;
                            w_done = 1'b1;
                        end else begin
                            n_beep = 1'b1;
                        end
                    end else begin
                        n_phase = w_phase_inc;
                    end
                end else begin
                    // idle: a tick changes nothing
                    n_mode = r_mode;
                end
            end
            CMD_SINGLE: begin
                n_mode   = MODE_SINGLE;
                n_sound  = w_beep_ext[TICK_WIDTH-1:0];
                n_cycles = '0;
                n_phase  = '0;
                n_beep   = 1'b1;
            end
            CMD_REPEAT: begin
                n_mode   = MODE_REPEAT;
                n_sound  = w_beep_ext[TICK_WIDTH-1:0];
                n_quiet  = w_silent_ext[TICK_WIDTH-1:0];
                n_target = w_count_ext[COUNT_WIDTH-1:0];
                n_cycles = '0;
                n_phase  = '0;
                n_beep   = 1'b1;
            end
            CMD_TONE: begin
                // flip the pin only in a sounding phase
                if (r_mode != MODE_IDLE && r_beep) begin
                    n_drive = ~r_drive;
                end
            end
            default: begin
                n_drive = r_drive;
            end
        endcase
    end

    // Result of this item, seen after its state update
    always_comb begin
        o_result.pin_level = n_drive;
        o_result.busy_res  = (n_mode != MODE_IDLE);
        o_result.sounding  = (n_mode != MODE_IDLE) && n_beep;
        o_result.finished  = w_done;
    end

    // Commit the state on each accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_IDLE;
            r_beep   <= 1'b0;
            r_phase  <= '0;
            r_cycles <= '0;
            r_sound  <= '0;
            r_quiet  <= '0;
            r_target <= '0;
            r_drive  <= 1'b0;
        end else if (i_accept) begin
            r_mode   <= n_mode;
            r_beep   <= n_beep;
            r_phase  <= n_phase;
            r_cycles <= n_cycles;
            r_sound  <= n_sound;
            r_quiet  <= n_quiet;
            r_target <= n_target;
            r_drive  <= n_drive;
        end
    end

    a_finish_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.finished |-> !o_result.busy_res)
        else $error("finished while still busy");

    a_start_sounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd == CMD_SINGLE || i_cmd == CMD_REPEAT) |-> o_result.sounding)
        else $error("start did not enter a sound phase");

    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && r_mode == MODE_IDLE && i_cmd != CMD_SINGLE && i_cmd != CMD_REPEAT)
        |=> (r_mode == MODE_IDLE) && $stable(r_drive))
        else $error("idle state moved without a start");

endmodule

`default_nettype wire

>>> rtl/beep_pattern_generator_top.sv
// Buzzer pattern sequencer.
// Slave channel: one transaction per item. tuser carries the command
// (tick, start single beep, start repeat pattern, tone half-period);
// tdata carries beep_ticks, silent_ticks and repeat_count.
// Master channel: one transaction per item with pin_level, busy_res and
// sounding in tdata; tlast marks the tick that ends a pattern.
// Each result is registered in the output register, or in the skid
// register if that one is held. Throughput: one item per cycle while
// s_tready is high, set by the pattern counter update per accepted item.
// A two-entry output stage (output register plus skid register) keeps
// s_tready high while one result waits; tready falls only when both are
// full, so a stalled receiver holds the queue and nothing is dropped.
// Reset clears the pattern to idle, the pin level to 0 and empties the
// output stage.
`default_nettype none

module beep_pattern_generator_top
    import bpg_pkg::*;
#(
    parameter int TICK_WIDTH  = 16,
    parameter int COUNT_WIDTH = 8
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_s_tvalid,
    output logic                     o_s_tready,
    // [15:0] beep_ticks, [31:16] silent_ticks, [39:32] repeat_count
    input  wire logic [S_DATA_W-1:0] i_s_tdata,
    // [1:0] cmd
    input  wire logic [1:0]          i_s_tuser,
    output logic                     o_m_tvalid,
    input  wire logic                i_m_tready,
    // [0] pin_level, [1] busy_res, [2] sounding, [7:3] zero
    output logic [M_DATA_W-1:0]      o_m_tdata,
    // finished
    output logic                     o_m_tlast
);

    logic    w_accept;
    logic    w_take;
    t_result w_res;

    logic    r_out_valid,  n_out_valid;
    t_result r_out,        n_out;
    logic    r_skid_valid, n_skid_valid;
    t_result r_skid,       n_skid;

    assign o_s_tready = !r_skid_valid;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_take     = r_out_valid && i_m_tready;

    bpg_core #(
        .TICK_WIDTH  (TICK_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (w_accept),
        .i_cmd          (i_s_tuser),
        .i_beep_ticks   (i_s_tdata[BEEP_W-1:0]),
        .i_silent_ticks (i_s_tdata[BEEP_W+SILENT_W-1:BEEP_W]),
        .i_repeat_count (i_s_tdata[S_DATA_W-1:BEEP_W+SILENT_W]),
        .o_result       (w_res)
    );

    // Steer results through the output and skid registers
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_skid_valid = r_skid_valid;
        n_skid       = r_skid;
        if (!r_out_valid || w_take) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid       = w_res;
                n_skid_valid = w_accept;
            end else begin
                n_out        = w_res;
                n_out_valid  = w_accept;
            end
        end else if (w_accept) begin
            n_skid       = w_res;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    // Payload needs no reset
    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(M_DATA_W-3){1'b0}}, r_out.sounding, r_out.busy_res,
                         r_out.pin_level};
    assign o_m_tlast  = r_out.finished;

    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held with empty output register");

    a_stall_fills_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_tready && !r_skid_valid && i_s_tvalid) |=> r_skid_valid)
        else $error("stalled result lost the next transaction");

    a_sounding_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.sounding |-> r_out.busy_res)
        else $error("sounding reported while idle");

endmodule

`default_nettype wire

>>> verif/tb_beep_pattern_generator_top.sv
`timescale 1ns / 1ps

module tb_beep_pattern_generator_top;
    import bpg_pkg::*;

    localparam int RESET_CYCLES   = 8;
    localparam int STALL_LIMIT    = 4000;
    localparam int ACTIVE_TARGET  = 800;
    localparam int DRAIN_CYCLES   = 16;
    localparam int MAX_REPORTS    = 60;
    localparam int SCRIPT_LEN     = 25;

    // Receiver stall styles
    typedef enum logic [1:0] {
        RDY_ALWAYS,
        RDY_COIN,
        RDY_PATTERN,
        RDY_SPARSE
    } t_ready_style;

    // Shadow copy of the sequencer state
    typedef struct {
        t_mode               mode;
        bit                  sound;
        bit [BEEP_W-1:0]     ticks;
        bit [COUNT_W-1:0]    cycles;
        bit [BEEP_W-1:0]     sound_len;
        bit [SILENT_W-1:0]   quiet_len;
        bit [COUNT_W-1:0]    target;
        bit                  level;
    } t_pattern_state;

    // One directed stimulus row; res is used only when fixed is set
    typedef struct {
        logic [1:0]          cmd;
        logic [BEEP_W-1:0]   beep;
        logic [SILENT_W-1:0] silent;
        logic [COUNT_W-1:0]  count;
        bit                  fixed;
        t_result             res;
    } t_script_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_s_tvalid = 1'b0;
    logic                o_s_tready;
    // [15:0] beep_ticks, [31:16] silent_ticks, [39:32] repeat_count
    logic [S_DATA_W-1:0] i_s_tdata = '0;
    // [1:0] cmd
    logic [1:0]          i_s_tuser = CMD_TICK;
    logic                o_m_tvalid;
    logic                i_m_tready = 1'b0;
    // [0] pin_level, [1] busy_res, [2] sounding, [7:3] zero
    logic [M_DATA_W-1:0] o_m_tdata;
    // finished
    logic                o_m_tlast;

    t_pattern_state pat;
    t_result        expected_results[$];
    t_script_row    script [SCRIPT_LEN];

    int mismatches    = 0;
    int results_seen  = 0;
    int stall_cycles  = 0;
    int burst_left    = 0;
    int starts_seen   = 0;
    int endings_seen  = 0;
    int toggles_seen  = 0;

    t_ready_style ready_style = RDY_ALWAYS;
    logic [15:0]  stall_mask  = 16'h00ff;
    int           ready_phase = 0;

    beep_pattern_generator_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Advance the shadow sequencer by one item and return its result
    function automatic t_result step_pattern(
        input logic [1:0]          cmd,
        input logic [BEEP_W-1:0]   beep,
        input logic [SILENT_W-1:0] silent,
        input logic [COUNT_W-1:0]  count
    );
        t_result r;
        bit      ended;
        ended = 1'b0;
        case (cmd)
            CMD_TICK: begin
                if (pat.mode != MODE_IDLE) begin
                    pat.ticks = pat.ticks + 1'b1;
                    if (pat.mode == MODE_SINGLE) begin
                        ended = (pat.ticks >= pat.sound_len);
                    end else if (pat.sound) begin
                        // sound phase over, go quiet
                        if (pat.ticks >= pat.sound_len) begin
                            pat.sound = 1'b0;
                            pat.ticks = '0;
                        end
                    end else if (pat.ticks >= pat.quiet_len) begin
                        // quiet phase over, close one cycle
                        pat.cycles = pat.cycles + 1'b1;
                        if (pat.cycles >= pat.target) begin
                            ended = 1'b1;
                        end else begin
                            pat.sound = 1'b1;
                            pat.ticks = '0;
                        end
                    end
                    if (ended) begin
                        pat.mode  = MODE_IDLE;
                        pat.sound = 1'b0;
                        pat.ticks = '0;
                        endings_seen++;
                    end
                end
            end
            CMD_SINGLE: begin
                pat.mode      = MODE_SINGLE;
                pat.sound_len = beep;
                pat.cycles    = '0;
                pat.ticks     = '0;
                pat.sound     = 1'b1;
                starts_seen++;
            end
            CMD_REPEAT: begin
                pat.mode      = MODE_REPEAT;
                pat.sound_len = beep;
                pat.quiet_len = silent;
                pat.target    = count;
                pat.cycles    = '0;
                pat.ticks     = '0;
                pat.sound     = 1'b1;
                starts_seen++;
            end
            default: begin
                // tone flips the pin only in a sounding phase
                if (pat.mode != MODE_IDLE && pat.sound) begin
                    pat.level = ~pat.level;
                    toggles_seen++;
                end
            end
        endcase
        r.pin_level = pat.level;
        r.busy_res  = (pat.mode != MODE_IDLE);
        r.sounding  = (pat.mode != MODE_IDLE) && pat.sound;
        r.finished  = ended;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        if (mismatches < MAX_REPORTS) begin
            $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        end
        mismatches++;
    endtask

    // Drive one item in the current burst, hold until accepted, then predict
    task automatic send_item(
        input  logic [1:0]          cmd,
        input  logic [BEEP_W-1:0]   beep,
        input  logic [SILENT_W-1:0] silent,
        input  logic [COUNT_W-1:0]  count,
        output t_result             predicted
    );
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge i_clk);
                i_s_tvalid <= 1'b0;
                i_s_tdata  <= S_DATA_W'({$urandom, $urandom});
                i_s_tuser  <= 2'($urandom);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {count, silent, beep};
        i_s_tuser  <= cmd;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        predicted = step_pattern(cmd, beep, silent, count);
    endtask

    // Receiver: stall on a randomly chosen style
    always @(negedge i_clk) begin
        ready_phase++;
        if (ready_phase % 64 == 0) begin
            ready_style = t_ready_style'($urandom_range(0, 3));
            stall_mask  = 16'($urandom) | 16'h0001;
        end
        case (ready_style)
            RDY_ALWAYS:  i_m_tready <= 1'b1;
            RDY_COIN:    i_m_tready <= 1'($urandom_range(0, 1));
            RDY_PATTERN: begin
                i_m_tready <= stall_mask[0];
                stall_mask = {stall_mask[0], stall_mask[15:1]};
            end
            default:     i_m_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Check each result transaction against the oldest expectation
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", o_m_tdata, 8'h00);
            end else begin
                want = expected_results.pop_front();
                if (o_m_tdata[0] !== want.pin_level)
                    report_mismatch("pin_level", o_m_tdata[0], want.pin_level);
                if (o_m_tdata[1] !== want.busy_res)
                    report_mismatch("busy_res", o_m_tdata[1], want.busy_res);
                if (o_m_tdata[2] !== want.sounding)
                    report_mismatch("sounding", o_m_tdata[2], want.sounding);
                if (o_m_tlast !== want.finished)
                    report_mismatch("finished", o_m_tlast, want.finished);
                if (o_m_tdata[7:3] !== 5'b0)
                    report_mismatch("tdata padding", o_m_tdata[7:3], 8'h00);
            end
        end
    end

    // Watchdog: end the run when no transaction moves for too long
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || !i_rst_n) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("[%0t] watchdog: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("tb_beep_pattern_generator_top: done, errors");
            $finish;
        end
    end

    initial begin
        t_result     predicted;
        logic [1:0]  cmd;
        logic [15:0] beep;
        logic [15:0] silent;
        logic [7:0]  count;
        bit          active;
        int          active_items;
        int          random_items;
        int          roll;

        // columns: cmd, beep_ticks, silent_ticks, repeat_count, fixed, {pin,busy,snd,fin}
        script = '{
            '{CMD_TICK,   16'h0000, 16'h0000, 8'h00, 1'b1, 4'b0000}, // tick at idle
            '{CMD_TONE,   16'h0000, 16'h0000, 8'h00, 1'b1, 4'b0000}, // tone at idle
            '{CMD_SINGLE, 16'h0000, 16'h0000, 8'h00, 1'b1, 4'b0110}, // zero-length beep
            '{CMD_TONE,   16'h0000, 16'h0000, 8'h00, 1'b1, 4'b1110},
            '{CMD_TICK,   16'h0000, 16'h0000, 8'h00, 1'b1, 4'b1001}, // still one tick
            '{CMD_TICK,   16'h0000, 16'h0000, 8'h00, 1'b1, 4'b1000},
            '{CMD_TONE,   16'h0000, 16'h0000, 8'h00, 1'b1, 4'b1000}, // pin holds at idle
            '{CMD_REPEAT, 16'h0000, 16'h0000, 8'h00, 1'b1, 4'b1110}, // all zero repeat
            '{CMD_TICK,   16'h0000, 16'h0000, 8'h00, 1'b1, 4'b1100},
            '{CMD_TONE,   16'h0000, 16'h0000, 8'h00, 1'b1, 4'b1100}, // tone in silence
            '{CMD_TICK,   16'h0000, 16'h0000, 8'h00, 1'b1, 4'b1001}, // zero count, one cycle
            '{CMD_REPEAT, 16'h0001, 16'h0002, 8'h02, 1'b0, 4'b0000},
            '{CMD_TONE,   16'h0000, 16'h0000, 8'h00, 1'b0, 4'b0000},
            '{CMD_TICK,   16'h0000, 16'h0000, 8'h00, 1'b0, 4'b0000},
            '{CMD_TONE,   16'h0000, 16'h0000, 8'h00, 1'b0, 4'b0000},
            '{CMD_TICK,   16'h0000, 16'h0000, 8'h00, 1'b0, 4'b0000},
            '{CMD_TICK,   16'h0000, 16'h0000, 8'h00, 1'b0, 4'b0000},
            '{CMD_TONE,   16'h0000, 16'h0000, 8'h00, 1'b0, 4'b0000},
            '{CMD_TICK,   16'h0000, 16'h0000, 8'h00, 1'b0, 4'b0000},
            '{CMD_TICK,   16'h0000, 16'h0000, 8'h00, 1'b0, 4'b0000},
            '{CMD_TICK,   16'h0000, 16'h0000, 8'h00, 1'b0, 4'b0000},
            '{CMD_SINGLE, 16'hffff, 16'hffff, 8'hff, 1'b0, 4'b0000}, // widest beep
            '{CMD_REPEAT, 16'hffff, 16'hffff, 8'hff, 1'b0, 4'b0000}, // restart while running
            '{CMD_TONE,   16'h0000, 16'h0000, 8'h00, 1'b0, 4'b0000},
            '{CMD_TICK,   16'h0000, 16'h0000, 8'h00, 1'b0, 4'b0000}
        };

        pat.mode      = MODE_IDLE;
        pat.sound     = 1'b0;
        pat.ticks     = '0;
        pat.cycles    = '0;
        pat.sound_len = '0;
        pat.quiet_len = '0;
        pat.target    = '0;
        pat.level     = 1'b0;
        active_items  = 0;
        random_items  = 0;

        // Hold reset, then release at a falling edge
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part
        foreach (script[i]) begin
            send_item(script[i].cmd, script[i].beep, script[i].silent, script[i].count,
                      predicted);
            expected_results.push_back(script[i].fixed ? script[i].res : predicted);
        end

        // Random part: mostly well-formed patterns, some noise and restarts
        while (active_items < ACTIVE_TARGET) begin
            roll   = $urandom_range(0, 99);
            beep   = 16'($urandom);
            silent = 16'($urandom);
            count  = 8'($urandom);
            if (pat.mode == MODE_IDLE) begin
                cmd = (roll < 70) ? ($urandom_range(0, 1) ? CMD_SINGLE : CMD_REPEAT)
                    : (roll < 85) ? CMD_TICK : CMD_TONE;
            end else begin
                cmd = (roll < 72) ? CMD_TICK
                    : (roll < 92) ? CMD_TONE
                    : (roll < 96) ? CMD_SINGLE : CMD_REPEAT;
            end
            // keep most patterns short enough to run to their end
            if ((cmd == CMD_SINGLE || cmd == CMD_REPEAT) && $urandom_range(0, 99) >= 12) begin
                beep   = 16'($urandom_range(0, 5));
                silent = 16'($urandom_range(0, 5));
                count  = 8'($urandom_range(0, 4));
            end
            active = (cmd == CMD_SINGLE) || (cmd == CMD_REPEAT)
                  || (cmd == CMD_TICK && pat.mode != MODE_IDLE)
                  || (cmd == CMD_TONE && pat.mode != MODE_IDLE && pat.sound);
            send_item(cmd, beep, silent, count, predicted);
            expected_results.push_back(predicted);
            if (active) active_items++;
            random_items++;
        end

        // Drop valid and drain
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d directed and %0d random items: %0d starts, %0d pattern ends,",
                 SCRIPT_LEN, random_items, starts_seen, endings_seen);
        $display("%0d tone toggles; %0d results checked under bursty input and stalled output",
                 toggles_seen, results_seen);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("tb_beep_pattern_generator_top: done, clean");
        end else begin
            $display("tb_beep_pattern_generator_top: done, errors");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/bpg_pkg.sv
rtl/bpg_core.sv
rtl/beep_pattern_generator_top.sv
verif/tb_beep_pattern_generator_top.sv
